// ----- hdl/tcc_pkg.sv -----
// Shared constants and types for the triangle circumcenter core.
`default_nettype none

package tcc_pkg;

    // Default coordinate width in bits, two's complement.
    localparam int COORD_WIDTH = 32;

    // Per-transaction flags that travel alongside the divider data.
    typedef struct packed {
        logic degen;
        logic neg_x;
        logic neg_y;
        logic big_x;
        logic big_y;
    } tcc_flags_t;

endpackage

`default_nettype wire

// ----- hdl/tcc_front.sv -----
// Front pipeline: corner differences, products, numerators and divider operands.
`default_nettype none

module tcc_front #(
    parameter int W = tcc_pkg::COORD_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  logic signed [W-1:0]     c0x,
    input  logic signed [W-1:0]     c0y,
    input  logic signed [W-1:0]     c1x,
    input  logic signed [W-1:0]     c1y,
    input  logic signed [W-1:0]     c2x,
    input  logic signed [W-1:0]     c2y,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output logic [3*W+4:0]          num_x,
    output logic [3*W+4:0]          num_y,
    output logic [2*W+3:0]          den,
    output logic signed [W-1:0]     base_x,
    output logic signed [W-1:0]     base_y,
    output tcc_pkg::tcc_flags_t     flags
);

    localparam int DFW = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int DSW = 2 * W + 4;
    localparam int SQW = 2 * W + 2;
    localparam int L   = W + 1;
    localparam int PPW = 2 * W + 4;
    localparam int NW  = 3 * W + 4;
    localparam int ANW = NW - 1;
    localparam int ADW = DSW - 1;
    localparam int RW  = 3 * W + 5;
    localparam int DW  = 2 * W + 4;
    localparam int K   = W + 1;
    localparam int NST = 9;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign up_ready = en[0];
    assign dn_valid = v_reg[NST-1];

    // Stage 1: offsets of the second and third corners from the first.
    logic signed [W-1:0]   s1_x0_reg, s1_y0_reg;
    logic signed [DFW-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_x0_reg <= c0x;
            s1_y0_reg <= c0y;
            s1_ax_reg <= DFW'(c1x) - DFW'(c0x);
            s1_ay_reg <= DFW'(c1y) - DFW'(c0y);
            s1_bx_reg <= DFW'(c2x) - DFW'(c0x);
            s1_by_reg <= DFW'(c2y) - DFW'(c0y);
        end
    end

    // Stage 2: the six narrow products.
    logic signed [W-1:0]   s2_x0_reg, s2_y0_reg;
    logic signed [DFW-1:0] s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic signed [PW-1:0]  s2_pab_reg, s2_pba_reg;
    logic signed [PW-1:0]  s2_pxx_reg, s2_pyy_reg, s2_qxx_reg, s2_qyy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_x0_reg  <= s1_x0_reg;
            s2_y0_reg  <= s1_y0_reg;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_bx_reg  <= s1_bx_reg;
            s2_by_reg  <= s1_by_reg;
            s2_pab_reg <= PW'(s1_ax_reg) * PW'(s1_by_reg);
            s2_pba_reg <= PW'(s1_ay_reg) * PW'(s1_bx_reg);
            s2_pxx_reg <= PW'(s1_ax_reg) * PW'(s1_ax_reg);
            s2_pyy_reg <= PW'(s1_ay_reg) * PW'(s1_ay_reg);
            s2_qxx_reg <= PW'(s1_bx_reg) * PW'(s1_bx_reg);
            s2_qyy_reg <= PW'(s1_by_reg) * PW'(s1_by_reg);
        end
    end

    // Stage 3: doubled determinant and the two squared side lengths.
    logic signed [W-1:0]   s3_x0_reg, s3_y0_reg;
    logic signed [DFW-1:0] s3_ax_reg, s3_ay_reg, s3_bx_reg, s3_by_reg;
    logic signed [DSW-1:0] s3_d_reg;
    logic [SQW-1:0]        s3_a2_reg, s3_b2_reg;
    logic signed [DSW-1:0] s3_dd;
    logic signed [PW-1:0]  s3_asum, s3_bsum;

    always_comb
    begin
        s3_dd   = DSW'(s2_pab_reg) - DSW'(s2_pba_reg);
        s3_asum = s2_pxx_reg + s2_pyy_reg;
        s3_bsum = s2_qxx_reg + s2_qyy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_x0_reg <= s2_x0_reg;
            s3_y0_reg <= s2_y0_reg;
            s3_ax_reg <= s2_ax_reg;
            s3_ay_reg <= s2_ay_reg;
            s3_bx_reg <= s2_bx_reg;
            s3_by_reg <= s2_by_reg;
            s3_d_reg  <= s3_dd <<< 1;
            s3_a2_reg <= $unsigned(s3_asum);
            s3_b2_reg <= $unsigned(s3_bsum);
        end
    end

    // Stage 4: partial products of the numerators, squares split in two halves.
    logic signed [W-1:0]   s4_x0_reg, s4_y0_reg;
    logic signed [DSW-1:0] s4_d_reg;
    logic                  s4_degen_reg;
    logic signed [PPW-1:0] s4_pp_reg [8];
    logic signed [PPW-1:0] a2_lo, a2_hi, b2_lo, b2_hi;

    always_comb
    begin
        a2_lo = PPW'($signed({1'b0, s3_a2_reg[L-1:0]}));
        a2_hi = PPW'($signed({1'b0, s3_a2_reg[SQW-1:L]}));
        b2_lo = PPW'($signed({1'b0, s3_b2_reg[L-1:0]}));
        b2_hi = PPW'($signed({1'b0, s3_b2_reg[SQW-1:L]}));
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_x0_reg    <= s3_x0_reg;
            s4_y0_reg    <= s3_y0_reg;
            s4_d_reg     <= s3_d_reg;
            s4_degen_reg <= (s3_d_reg == '0);
            s4_pp_reg[0] <= PPW'(s3_by_reg) * a2_lo;
            s4_pp_reg[1] <= PPW'(s3_by_reg) * a2_hi;
            s4_pp_reg[2] <= PPW'(s3_ay_reg) * b2_lo;
            s4_pp_reg[3] <= PPW'(s3_ay_reg) * b2_hi;
            s4_pp_reg[4] <= PPW'(s3_ax_reg) * b2_lo;
            s4_pp_reg[5] <= PPW'(s3_ax_reg) * b2_hi;
            s4_pp_reg[6] <= PPW'(s3_bx_reg) * a2_lo;
            s4_pp_reg[7] <= PPW'(s3_bx_reg) * a2_hi;
        end
    end

    // Stage 5: recombine the halves into full products.
    logic signed [W-1:0]   s5_x0_reg, s5_y0_reg;
    logic signed [DSW-1:0] s5_d_reg;
    logic                  s5_degen_reg;
    logic signed [NW-1:0]  s5_t_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_x0_reg    <= s4_x0_reg;
            s5_y0_reg    <= s4_y0_reg;
            s5_d_reg     <= s4_d_reg;
            s5_degen_reg <= s4_degen_reg;
            for (int i = 0; i < 4; i++)
            begin
                s5_t_reg[i] <= (NW'(s4_pp_reg[2*i+1]) <<< L) + NW'(s4_pp_reg[2*i]);
            end
        end
    end

    // Stage 6: the two numerators.
    logic signed [W-1:0]   s6_x0_reg, s6_y0_reg;
    logic signed [DSW-1:0] s6_d_reg;
    logic                  s6_degen_reg;
    logic signed [NW-1:0]  s6_nx_reg, s6_ny_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_x0_reg    <= s5_x0_reg;
            s6_y0_reg    <= s5_y0_reg;
            s6_d_reg     <= s5_d_reg;
            s6_degen_reg <= s5_degen_reg;
            s6_nx_reg    <= s5_t_reg[0] - s5_t_reg[1];
            s6_ny_reg    <= s5_t_reg[2] - s5_t_reg[3];
        end
    end

    // Stage 7: magnitudes and quotient signs.
    logic signed [W-1:0]   s7_x0_reg, s7_y0_reg;
    logic                  s7_degen_reg, s7_neg_x_reg, s7_neg_y_reg;
    logic [ANW-1:0]        s7_anx_reg, s7_any_reg;
    logic [ADW-1:0]        s7_ad_reg;
    logic signed [NW-1:0]  s7_mx, s7_my;
    logic signed [DSW-1:0] s7_md;

    always_comb
    begin
        s7_mx = s6_nx_reg[NW-1] ? -s6_nx_reg : s6_nx_reg;
        s7_my = s6_ny_reg[NW-1] ? -s6_ny_reg : s6_ny_reg;
        s7_md = s6_d_reg[DSW-1] ? -s6_d_reg : s6_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_x0_reg    <= s6_x0_reg;
            s7_y0_reg    <= s6_y0_reg;
            s7_degen_reg <= s6_degen_reg;
            s7_neg_x_reg <= s6_nx_reg[NW-1] ^ s6_d_reg[DSW-1];
            s7_neg_y_reg <= s6_ny_reg[NW-1] ^ s6_d_reg[DSW-1];
            s7_anx_reg   <= s7_mx[ANW-1:0];
            s7_any_reg   <= s7_my[ANW-1:0];
            s7_ad_reg    <= s7_md[ADW-1:0];
        end
    end

    // Stage 8: round-half-away operands, (2|n| + |d|) over 2|d|.
    logic signed [W-1:0] s8_x0_reg, s8_y0_reg;
    logic                s8_degen_reg, s8_neg_x_reg, s8_neg_y_reg;
    logic [RW-1:0]       s8_numx_reg, s8_numy_reg;
    logic [DW-1:0]       s8_den_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_x0_reg    <= s7_x0_reg;
            s8_y0_reg    <= s7_y0_reg;
            s8_degen_reg <= s7_degen_reg;
            s8_neg_x_reg <= s7_neg_x_reg;
            s8_neg_y_reg <= s7_neg_y_reg;
            s8_numx_reg  <= (RW'(s7_anx_reg) << 1) + RW'(s7_ad_reg);
            s8_numy_reg  <= (RW'(s7_any_reg) << 1) + RW'(s7_ad_reg);
            s8_den_reg   <= DW'(s7_ad_reg) << 1;
        end
    end

    // Stage 9: flags each quotient too large for the divider chain; it saturates unless degenerate.
    logic signed [W-1:0] s9_x0_reg, s9_y0_reg;
    logic [RW-1:0]       s9_numx_reg, s9_numy_reg;
    logic [DW-1:0]       s9_den_reg;
    tcc_pkg::tcc_flags_t s9_flags_reg;
    logic [RW-1:0]       den_top;

    assign den_top = RW'(s8_den_reg) << K;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s9_x0_reg          <= s8_x0_reg;
            s9_y0_reg          <= s8_y0_reg;
            s9_numx_reg        <= s8_numx_reg;
            s9_numy_reg        <= s8_numy_reg;
            s9_den_reg         <= s8_den_reg;
            s9_flags_reg.degen <= s8_degen_reg;
            s9_flags_reg.neg_x <= s8_neg_x_reg;
            s9_flags_reg.neg_y <= s8_neg_y_reg;
            s9_flags_reg.big_x <= (s8_numx_reg >= den_top);
            s9_flags_reg.big_y <= (s8_numy_reg >= den_top);
        end
    end

    assign num_x  = s9_numx_reg;
    assign num_y  = s9_numy_reg;
    assign den    = s9_den_reg;
    assign base_x = s9_x0_reg;
    assign base_y = s9_y0_reg;
    assign flags  = s9_flags_reg;

endmodule

`default_nettype wire

// ----- hdl/tcc_div_cell.sv -----
// One restoring-division cell: decides one quotient bit for both coordinates.
`default_nettype none

module tcc_div_cell #(
    parameter int W    = tcc_pkg::COORD_WIDTH,
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  logic [3*W+4:0]          rem_x_in,
    input  logic [3*W+4:0]          rem_y_in,
    input  logic [2*W+3:0]          den_in,
    input  logic [W:0]              qx_in,
    input  logic [W:0]              qy_in,
    input  logic signed [W-1:0]     base_x_in,
    input  logic signed [W-1:0]     base_y_in,
    input  tcc_pkg::tcc_flags_t     flags_in,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output logic [3*W+4:0]          rem_x_out,
    output logic [3*W+4:0]          rem_y_out,
    output logic [2*W+3:0]          den_out,
    output logic [W:0]              qx_out,
    output logic [W:0]              qy_out,
    output logic signed [W-1:0]     base_x_out,
    output logic signed [W-1:0]     base_y_out,
    output tcc_pkg::tcc_flags_t     flags_out
);

    localparam int RW = 3 * W + 5;

    logic          valid_reg;
    logic          en;
    logic [RW:0]   dsh, trial_x, trial_y;
    logic [RW-1:0] rem_x_next, rem_y_next;
    logic [W:0]    qx_next, qy_next;

    logic [RW-1:0]       rem_x_reg, rem_y_reg;
    logic [2*W+3:0]      den_reg;
    logic [W:0]          qx_reg, qy_reg;
    logic signed [W-1:0] base_x_reg, base_y_reg;
    tcc_pkg::tcc_flags_t flags_reg;

    assign en       = !valid_reg || dn_ready;
    assign up_ready = en;

    always_comb
    begin
        dsh        = (RW + 1)'(den_in) << STEP;
        trial_x    = {1'b0, rem_x_in} - dsh;
        trial_y    = {1'b0, rem_y_in} - dsh;
        rem_x_next = trial_x[RW] ? rem_x_in : trial_x[RW-1:0];
        rem_y_next = trial_y[RW] ? rem_y_in : trial_y[RW-1:0];
        qx_next       = qx_in;
        qy_next       = qy_in;
        qx_next[STEP] = !trial_x[RW];
        qy_next[STEP] = !trial_y[RW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg  <= rem_x_next;
            rem_y_reg  <= rem_y_next;
            den_reg    <= den_in;
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            base_x_reg <= base_x_in;
            base_y_reg <= base_y_in;
            flags_reg  <= flags_in;
        end
    end

    assign dn_valid   = valid_reg;
    assign rem_x_out  = rem_x_reg;
    assign rem_y_out  = rem_y_reg;
    assign den_out    = den_reg;
    assign qx_out     = qx_reg;
    assign qy_out     = qy_reg;
    assign base_x_out = base_x_reg;
    assign base_y_out = base_y_reg;
    assign flags_out  = flags_reg;

endmodule

`default_nettype wire

// ----- hdl/triangle_circumcenter_core.sv -----
// Top level: circumcenter of a triangle in signed fixed point, one per cycle while center_stall is low.
//
//   channel  | direction | handshake                    | payload
//   corner   | in        | corner_valid / corner_stall  | corner0_x .. corner2_y
//   center   | out       | center_valid / center_stall  | center_x, center_y,
//            |           |                              | degenerate, overflow
//
// One transaction per cycle is sustained while center_stall is low; the path runs through
// nine arithmetic stages, a row of COORD_WIDTH + 1 divider cells and one output register.
// The divider row, one quotient bit per cell, sets the latency.
// Reset clears only the valid bits of the stages; no clearing pass is needed.
// Every stage holds its data under stall and fills bubbles independently, so new
// corners are taken while a finished result waits at the output.
`default_nettype none

module triangle_circumcenter_core #(
    parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          corner_valid,
    output logic                          corner_stall,
    input  logic signed [COORD_WIDTH-1:0] corner0_x,
    input  logic signed [COORD_WIDTH-1:0] corner0_y,
    input  logic signed [COORD_WIDTH-1:0] corner1_x,
    input  logic signed [COORD_WIDTH-1:0] corner1_y,
    input  logic signed [COORD_WIDTH-1:0] corner2_x,
    input  logic signed [COORD_WIDTH-1:0] corner2_y,
    output logic                          center_valid,
    input  logic                          center_stall,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic                          degenerate,
    output logic                          overflow
);

    localparam int W  = COORD_WIDTH;
    localparam int K  = W + 1;
    localparam int RW = 3 * W + 5;
    localparam int DW = 2 * W + 4;
    localparam int SW = W + 3;

    localparam logic signed [SW-1:0] SAT_HI = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {4'b1111, {(W-1){1'b0}}};

    logic                v   [K+1];
    logic                rdy [K+1];
    logic [RW-1:0]       rx  [K+1];
    logic [RW-1:0]       ry  [K+1];
    logic [DW-1:0]       dn  [K+1];
    logic [K-1:0]        qx  [K+1];
    logic [K-1:0]        qy  [K+1];
    logic signed [W-1:0] bx  [K+1];
    logic signed [W-1:0] by  [K+1];
    tcc_pkg::tcc_flags_t fl  [K+1];

    logic front_ready;

    tcc_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (corner_valid),
        .up_ready (front_ready),
        .c0x      (corner0_x),
        .c0y      (corner0_y),
        .c1x      (corner1_x),
        .c1y      (corner1_y),
        .c2x      (corner2_x),
        .c2y      (corner2_y),
        .dn_valid (v[0]),
        .dn_ready (rdy[0]),
        .num_x    (rx[0]),
        .num_y    (ry[0]),
        .den      (dn[0]),
        .base_x   (bx[0]),
        .base_y   (by[0]),
        .flags    (fl[0])
    );

    assign qx[0] = '0;
    assign qy[0] = '0;
    assign corner_stall = !front_ready;

    // Cell i decides quotient bit K-1-i, most significant first.
    for (genvar i = 0; i < K; i++)
    begin : g_cell
        tcc_div_cell #(.W(W), .STEP(K - 1 - i)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (v[i]),
            .up_ready   (rdy[i]),
            .rem_x_in   (rx[i]),
            .rem_y_in   (ry[i]),
            .den_in     (dn[i]),
            .qx_in      (qx[i]),
            .qy_in      (qy[i]),
            .base_x_in  (bx[i]),
            .base_y_in  (by[i]),
            .flags_in   (fl[i]),
            .dn_valid   (v[i+1]),
            .dn_ready   (rdy[i+1]),
            .rem_x_out  (rx[i+1]),
            .rem_y_out  (ry[i+1]),
            .den_out    (dn[i+1]),
            .qx_out     (qx[i+1]),
            .qy_out     (qy[i+1]),
            .base_x_out (bx[i+1]),
            .base_y_out (by[i+1]),
            .flags_out  (fl[i+1])
        );
    end

    // Output register: offset the rounded quotient onto the first corner and clamp.
    logic                center_valid_reg;
    logic signed [W-1:0] center_x_reg, center_y_reg;
    logic                degenerate_reg, overflow_reg;
    logic                out_en;
    logic signed [SW-1:0] sx, sy;
    logic                hi_x, lo_x, hi_y, lo_y;
    logic signed [W-1:0] cx_next, cy_next;
    logic                ovf_next;
    tcc_pkg::tcc_flags_t f_last;

    assign out_en = !center_valid_reg || !center_stall;
    assign rdy[K] = out_en;
    assign f_last = fl[K];

    always_comb
    begin
        sx = f_last.neg_x ? SW'(bx[K]) - $signed({2'b00, qx[K]})
                          : SW'(bx[K]) + $signed({2'b00, qx[K]});
        sy = f_last.neg_y ? SW'(by[K]) - $signed({2'b00, qy[K]})
                          : SW'(by[K]) + $signed({2'b00, qy[K]});
        hi_x = f_last.big_x ? !f_last.neg_x : (sx > SAT_HI);
        lo_x = f_last.big_x ?  f_last.neg_x : (sx < SAT_LO);
        hi_y = f_last.big_y ? !f_last.neg_y : (sy > SAT_HI);
        lo_y = f_last.big_y ?  f_last.neg_y : (sy < SAT_LO);
        cx_next = hi_x ? SAT_HI[W-1:0] : (lo_x ? SAT_LO[W-1:0] : sx[W-1:0]);
        cy_next = hi_y ? SAT_HI[W-1:0] : (lo_y ? SAT_LO[W-1:0] : sy[W-1:0]);
        ovf_next = hi_x || lo_x || hi_y || lo_y;
        if (f_last.degen)
        begin
            cx_next  = '0;
            cy_next  = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            center_valid_reg <= v[K];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            center_x_reg   <= cx_next;
            center_y_reg   <= cy_next;
            degenerate_reg <= f_last.degen;
            overflow_reg   <= ovf_next;
        end
    end

    assign center_valid = center_valid_reg;
    assign center_x     = center_x_reg;
    assign center_y     = center_y_reg;
    assign degenerate   = degenerate_reg;
    assign overflow     = overflow_reg;

    // A collinear result carries a zero center and never reports saturation.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && degenerate |-> center_x == '0 && center_y == '0 && !overflow)
        else $error("degenerate result with nonzero center or overflow");

    // An empty output register can always take data, so the input never stalls.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !center_valid |-> !corner_stall)
        else $error("input stalled while output register empty");

    // Backpressure only originates at the output channel.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !center_stall |-> !corner_stall)
        else $error("input stalled without output stall");

    // An overflow always leaves at least one coordinate at a range limit.
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && overflow |->
            center_x == SAT_HI[W-1:0] || center_x == SAT_LO[W-1:0] ||
            center_y == SAT_HI[W-1:0] || center_y == SAT_LO[W-1:0])
        else $error("overflow flagged without a saturated coordinate");

endmodule

`default_nettype wire

// ----- tb/triangle_circumcenter_core_tb.sv -----
// Self-checking testbench for the triangle circumcenter core.
`default_nettype none

module triangle_circumcenter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = tcc_pkg::COORD_WIDTH;
    localparam int LATENCY = CW + 11;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1030;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t x0, y0, x1, y1, x2, y2;
    } triangle_t;

    typedef struct {
        coord_t cx, cy;
        logic   degen;
        logic   ovf;
    } center_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   corner_valid = 1'b0;
    logic   corner_stall;
    coord_t corner0_x = '0, corner0_y = '0, corner1_x = '0;
    coord_t corner1_y = '0, corner2_x = '0, corner2_y = '0;
    logic   center_valid;
    logic   center_stall = 1'b1;
    coord_t center_x, center_y;
    logic   degenerate, overflow;

    triangle_t pending_triangles[$];
    center_t   expected_centers[$];
    int        error_count = 0;
    int        accepted_count = 0;
    int        received_count = 0;
    int        degen_seen = 0;
    int        ovf_seen = 0;
    int        idle_pct = 19;
    int        hold_left = 0;
    bit        hold_request = 1'b0;
    bit        sender_pause = 1'b0;

    always #4 clk = ~clk;

    triangle_circumcenter_core u_top (
        .clk(clk), .rst_n(rst_n),
        .corner_valid(corner_valid), .corner_stall(corner_stall),
        .corner0_x(corner0_x), .corner0_y(corner0_y),
        .corner1_x(corner1_x), .corner1_y(corner1_y),
        .corner2_x(corner2_x), .corner2_y(corner2_y),
        .center_valid(center_valid), .center_stall(center_stall),
        .center_x(center_x), .center_y(center_y),
        .degenerate(degenerate), .overflow(overflow)
    );

    // Rounded quotient (ties away from zero) added to the base, saturated.
    function automatic coord_t offset_round(input coord_t base,
                                            input logic signed [199:0] n,
                                            input logic signed [199:0] d,
                                            inout logic ovf);
        logic [199:0] an, ad, q;
        logic signed [199:0] s;
        logic signed [199:0] hi, lo;
        an = n[199] ? -n : n;
        ad = d[199] ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        s = (n[199] != d[199]) ? $signed({{168{base[CW-1]}}, base}) - $signed(q)
                               : $signed({{168{base[CW-1]}}, base}) + $signed(q);
        hi = (200'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (s > hi) begin
            ovf = 1'b1;
            return {1'b0, {(CW-1){1'b1}}};
        end
        if (s < lo) begin
            ovf = 1'b1;
            return {1'b1, {(CW-1){1'b0}}};
        end
        return s[CW-1:0];
    endfunction

    function automatic center_t circumcenter(input triangle_t t);
        logic signed [199:0] ax, ay, bx, by, d, a2, b2, nx, ny;
        center_t r;
        ax = $signed(t.x1) - $signed(t.x0);
        ay = $signed(t.y1) - $signed(t.y0);
        bx = $signed(t.x2) - $signed(t.x0);
        by = $signed(t.y2) - $signed(t.y0);
        d = 2 * (ax * by - ay * bx);
        r.cx = '0;
        r.cy = '0;
        r.degen = 1'b0;
        r.ovf = 1'b0;
        if (d == 0) begin
            r.degen = 1'b1;
            return r;
        end
        a2 = ax * ax + ay * ay;
        b2 = bx * bx + by * by;
        nx = by * a2 - ay * b2;
        ny = ax * b2 - bx * a2;
        r.cx = offset_round(t.x0, nx, d, r.ovf);
        r.cy = offset_round(t.y0, ny, d, r.ovf);
        return r;
    endfunction

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return ($urandom_range(0, 1) != 0) ? {1'b0, {(CW-1){1'b1}}}
                                                        : {1'b1, {(CW-1){1'b0}}};
        endcase
    endfunction

    function automatic triangle_t tri_of(input coord_t a, b, c, d, e, f);
        triangle_t t;
        t.x0 = a; t.y0 = b; t.x1 = c; t.y1 = d; t.x2 = e; t.y2 = f;
        return t;
    endfunction

    // Driver: presents queued triangles, idles at random, obeys the pause.
    always @(posedge clk) begin
        if (rst_n) begin
            if (corner_valid && !corner_stall) begin
                expected_centers.push_back(circumcenter(tri_of(corner0_x, corner0_y,
                    corner1_x, corner1_y, corner2_x, corner2_y)));
                accepted_count <= accepted_count + 1;
            end
            if (!corner_valid || !corner_stall) begin
                if (pending_triangles.size() != 0 && !sender_pause
                    && $urandom_range(0, 99) >= idle_pct) begin
                    triangle_t t;
                    t = pending_triangles.pop_front();
                    corner_valid <= 1'b1;
                    corner0_x <= t.x0; corner0_y <= t.y0;
                    corner1_x <= t.x1; corner1_y <= t.y1;
                    corner2_x <= t.x2; corner2_y <= t.y2;
                end else begin
                    corner_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each transaction against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n) begin
            if (center_valid && !center_stall) begin
                received_count <= received_count + 1;
                if (expected_centers.size() == 0) begin
                    $error("unexpected result transaction");
                    error_count++;
                end else begin
                    center_t e;
                    e = expected_centers.pop_front();
                    if (degenerate) degen_seen++;
                    if (overflow) ovf_seen++;
                    if (center_x !== e.cx) begin
                        $error("center_x expected %0d got %0d", e.cx, center_x);
                        error_count++;
                    end
                    if (center_y !== e.cy) begin
                        $error("center_y expected %0d got %0d", e.cy, center_y);
                        error_count++;
                    end
                    if (degenerate !== e.degen) begin
                        $error("degenerate expected %0b got %0b", e.degen, degenerate);
                        error_count++;
                    end
                    if (overflow !== e.ovf) begin
                        $error("overflow expected %0b got %0b", e.ovf, overflow);
                        error_count++;
                    end
                end
            end
            if (hold_request && hold_left == 0) begin
                hold_left <= HOLD_CYCLES;
                center_stall <= 1'b1;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
                center_stall <= 1'b1;
            end else begin
                hold_left <= 0;
                center_stall <= ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((corner_valid && !corner_stall) || (center_valid && !center_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("triangle_circumcenter_core: mismatch");
            $finish;
        end
    end

    initial begin
        coord_t mx, mn;
        int mode;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        // Directed: plain, collinear, coincident, right angles, extremes.
        pending_triangles.push_back(tri_of(0, 0, 32'sh20000, 0, 0, 32'sh20000));
        pending_triangles.push_back(tri_of(0, 0, 32'sh10000, 32'sh10000, 32'sh20000,
                                           32'sh20000));
        pending_triangles.push_back(tri_of(5, 7, 5, 7, 5, 7));
        pending_triangles.push_back(tri_of(1, 1, 1, 1, 9, 3));
        pending_triangles.push_back(tri_of(0, 0, 10, 0, 3, 4));
        pending_triangles.push_back(tri_of(0, 0, 0, 10, 4, 3));
        pending_triangles.push_back(tri_of(0, 0, 1, 0, 0, 1));
        pending_triangles.push_back(tri_of(0, 0, 3, 0, 0, 1));
        pending_triangles.push_back(tri_of(0, 0, -3, 0, 0, -1));
        pending_triangles.push_back(tri_of(mx, mx, mn, mn, mx, mn));
        pending_triangles.push_back(tri_of(mn, mn, mx, mn, mn, mx));
        pending_triangles.push_back(tri_of(0, 0, 1, 0, 2, 1));
        pending_triangles.push_back(tri_of(0, 0, 1000, 1, 2000, 3));
        pending_triangles.push_back(tri_of(mx, 0, mx - 1, 1, mx, 2));
        pending_triangles.push_back(tri_of(mn, 0, mn + 1, 1, mn, 2));
        pending_triangles.push_back(tri_of(mx, mn, mx, mx, mn, mn));
        pending_triangles.push_back(tri_of(-1, -1, mx, mx, mn, mn));
        pending_triangles.push_back(tri_of(32'h5555_5555, 32'hAAAA_AAAA, -1, 0,
                                           32'h0F0F_0F0F, 32'hF0F0_F0F0));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                // Collinear: third corner on the line through the first two.
                coord_t bx, by;
                int k;
                bx = rand_coord(1);
                by = rand_coord(1);
                k = $signed($urandom_range(0, 6)) - 3;
                pending_triangles.push_back(tri_of(bx, by, bx + 7 * i % 50, by + 3,
                    bx + k * (7 * i % 50), by + k * 3));
            end else begin
                int m;
                m = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : 3;
                pending_triangles.push_back(tri_of(rand_coord(m), rand_coord(m),
                    rand_coord(m == 3 ? 0 : m), rand_coord(m), rand_coord(m),
                    rand_coord(m == 3 ? 1 : m)));
            end
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Long receiver hold while the sender keeps offering.
        wait (accepted_count >= 200);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;

        // Sender pause until the pipeline drains.
        wait (accepted_count >= 500);
        @(posedge clk);
        sender_pause <= 1'b1;
        wait (expected_centers.size() == 0);
        @(posedge clk);
        sender_pause <= 1'b0;

        // Stretch with no idling on either side.
        wait (accepted_count >= 650);
        idle_pct = 0;
        wait (accepted_count >= 850);
        idle_pct = 19;

        wait (pending_triangles.size() == 0 && !corner_valid);
        wait (expected_centers.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d triangles in, %0d centers out (%0d collinear, %0d saturated),",
                 accepted_count, received_count, degen_seen, ovf_seen);
        $display("with random idles, a long output hold and a full drain pause.");
        if (error_count == 0 && expected_centers.size() == 0)
            $display("triangle_circumcenter_core: match");
        else
            $display("triangle_circumcenter_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
